[design/stx_packet_deframer_crc16_macros.svh]
// Assertion macros for the STX packet deframer.
// Used by the top level; needs nothing else.
`ifndef STX_PACKET_DEFRAMER_CRC16_MACROS_SVH
`define STX_PACKET_DEFRAMER_CRC16_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/spd_pkg.sv]
// Shared constants, types and the CRC byte update for the STX deframer.
// No dependencies.
package spd_pkg;

  localparam logic [7:0]  STX_BYTE  = 8'h02;
  localparam int          MIN_FRAME = 6;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam int          DEF_DEPTH = 64;
  localparam int          STAT_W    = 7;
  localparam int          IDX_W     = 8;

  localparam logic [IDX_W-1:0] REG_CRC_INIT = 8'd0;
  localparam logic [IDX_W-1:0] REG_INFO_CMD = 8'd1;

  localparam logic [1:0] EV_BAD  = 2'd0;
  localparam logic [1:0] EV_DUP  = 2'd1;
  localparam logic [1:0] EV_INFO = 2'd2;
  localparam logic [1:0] EV_UNK  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cmd;
    logic [7:0] id;
    logic [5:0] plen;
    logic       last;
  } event_t;

  typedef struct packed {
    logic [STAT_W-1:0] fill;
    logic              busy;
  } status_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[design/spd_if.sv]
// Handshake interfaces of the STX deframer: byte in, event out, config write.
// Depends on spd_pkg for the index width.
interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] packet_cmd;
  logic [7:0] packet_id;
  logic [5:0] payload_length;
  logic       last_event;
  modport source (output valid, output event_kind, output packet_cmd, output packet_id,
                  output payload_length, output last_event, input ready);
  modport sink (input valid, input event_kind, input packet_cmd, input packet_id,
                input payload_length, input last_event, output ready);
endinterface

interface spd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::IDX_W-1:0] index;
  logic [15:0]               data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/spd_in_fifo.sv]
// Front end: two-word queue that takes received bytes from the link.
// Depends on spd_if.
module spd_in_fifo (
  input  logic       clk,
  input  logic       rst,
  spd_byte_if.sink   rx,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       q_pop
);

  logic [1:0] level;
  logic [7:0] d0;
  logic [7:0] d1;
  logic       push;
  logic       pop;

  assign rx.ready = (level < 2'd2);
  assign push     = rx.valid && rx.ready;
  assign pop      = q_pop && (level != 2'd0);
  assign q_valid  = (level != 2'd0);
  assign q_byte   = d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (level == 2'd0) d0 <= rx.rx_byte;
          else d1 <= rx.rx_byte;
          level <= level + 2'd1;
        end
        2'b01: begin
          d0    <= d1;
          level <= level - 2'd1;
        end
        2'b11: begin
          if (level == 2'd1) begin
            d0 <= rx.rx_byte;
          end else begin
            d0 <= d1;
            d1 <= rx.rx_byte;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/spd_engine.sv]
// Back end: frame buffer, STX hunt, length and CRC check, event output register.
// Depends on spd_pkg and spd_if.
module spd_engine #(
  parameter int BUFFER_DEPTH = spd_pkg::DEF_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [7:0]       q_byte,
  output logic             q_pop,
  input  logic [15:0]      crc_init,
  input  logic [7:0]       info_cmd,
  spd_event_if.source      evt,
  output spd_pkg::status_t status
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RHEAD = 4'd1;
  localparam logic [3:0] S_CHEAD = 4'd2;
  localparam logic [3:0] S_CLEN  = 4'd3;
  localparam logic [3:0] S_CRC   = 4'd4;
  localparam logic [3:0] S_RLO   = 4'd5;
  localparam logic [3:0] S_RHI   = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  rdata;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;

  logic [3:0]    state;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] len_r;
  logic [CW-1:0] idx;
  logic [15:0]   crc;
  logic [7:0]    cmd;
  logic [7:0]    id;
  logic [7:0]    crc_lo;
  logic [7:0]    prev_id;
  logic          prev_valid;
  spd_pkg::event_t ev;
  spd_pkg::event_t pend;
  logic            pend_valid;
  spd_pkg::event_t out_r;
  logic            out_valid;
  logic            can_push;
  logic            push;
  logic            good;

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-PW){1'b0}}, p} + {1'b0, off};
    if (s >= (CW+1)'(BUFFER_DEPTH)) s = s - (CW+1)'(BUFFER_DEPTH);
    return s[PW-1:0];
  endfunction

  assign can_push = !out_valid || evt.ready;
  assign push     = ((state == S_EMIT) || (state == S_DONE)) && pend_valid && can_push;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign waddr    = (count == CW'(BUFFER_DEPTH)) ? head : wrap(head, count);
  assign good     = (crc == {rdata, crc_lo});

  always_comb begin
    case (state)
      S_CHEAD: raddr = wrap(head, CW'(1));
      S_CRC:   raddr = (idx == len_r - CW'(3)) ? wrap(head, len_r - CW'(2))
                                               : wrap(head, idx + CW'(1));
      S_RLO:   raddr = wrap(head, len_r - CW'(1));
      default: raddr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) mem[waddr] <= q_byte;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      prev_id    <= 8'd0;
      prev_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        out_r     <= '{kind: pend.kind, cmd: pend.cmd, id: pend.id, plen: pend.plen,
                       last: (state == S_DONE)};
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            count <= (count == CW'(BUFFER_DEPTH)) ? CW'(1) : count + CW'(1);
            state <= S_RHEAD;
          end
        end
        S_RHEAD: begin
          state <= (count == '0) ? S_DONE : S_CHEAD;
        end
        S_CHEAD: begin
          if (rdata != spd_pkg::STX_BYTE) begin
            // discard leading garbage one byte at a time
            head  <= wrap(head, CW'(1));
            count <= count - CW'(1);
            state <= S_RHEAD;
          end else if (count < CW'(2)) begin
            state <= S_DONE;
          end else begin
            state <= S_CLEN;
          end
        end
        S_CLEN: begin
          if ((rdata > 8'(BUFFER_DEPTH)) ||
              ((rdata <= 8'(count)) && (rdata < 8'(spd_pkg::MIN_FRAME)))) begin
            ev    <= '{kind: spd_pkg::EV_BAD, cmd: 8'd0, id: 8'd0, plen: 6'd0, last: 1'b0};
            head  <= wrap(head, CW'(1));
            count <= count - CW'(1);
            state <= S_EMIT;
          end else if (rdata > 8'(count)) begin
            state <= S_DONE;
          end else begin
            len_r <= rdata[CW-1:0];
            idx   <= '0;
            crc   <= crc_init;
            state <= S_CRC;
          end
        end
        S_CRC: begin
          crc <= spd_pkg::crc_byte(crc, rdata);
          if (idx == CW'(2)) cmd <= rdata;
          if (idx == CW'(3)) id <= rdata;
          idx <= idx + CW'(1);
          if (idx == len_r - CW'(3)) state <= S_RLO;
        end
        S_RLO: begin
          crc_lo <= rdata;
          state  <= S_RHI;
        end
        S_RHI: begin
          if (good) begin
            ev.cmd  <= cmd;
            ev.id   <= id;
            ev.plen <= 6'(len_r - CW'(spd_pkg::MIN_FRAME));
            ev.last <= 1'b0;
            if (prev_valid && (prev_id == id)) begin
              ev.kind <= spd_pkg::EV_DUP;
            end else begin
              ev.kind    <= (cmd == info_cmd) ? spd_pkg::EV_INFO : spd_pkg::EV_UNK;
              prev_id    <= id;
              prev_valid <= 1'b1;
            end
            head  <= wrap(head, len_r);
            count <= count - len_r;
          end else begin
            ev    <= '{kind: spd_pkg::EV_BAD, cmd: 8'd0, id: 8'd0, plen: 6'd0, last: 1'b0};
            head  <= wrap(head, CW'(1));
            count <= count - CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold the newest event back until we know whether it is the last
          if (!pend_valid || can_push) begin
            pend       <= ev;
            pend_valid <= 1'b1;
            state      <= S_RHEAD;
          end
        end
        S_DONE: begin
          if (!pend_valid || can_push) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign evt.valid          = out_valid;
  assign evt.event_kind     = out_r.kind;
  assign evt.packet_cmd     = out_r.cmd;
  assign evt.packet_id      = out_r.id;
  assign evt.payload_length = out_r.plen;
  assign evt.last_event     = out_r.last;

  assign status.fill = spd_pkg::STAT_W'(count);
  assign status.busy = (state != S_IDLE);

endmodule

[design/stx_packet_deframer_crc16.sv]
// Top level of the STX/length framed packet deframer with CRC-16 check.
// Depends on spd_pkg, spd_if, spd_in_fifo, spd_engine and the macros header.
//
// Channels: rx carries one received byte per word (valid/ready); evt returns
// one event per word: kind, cmd, id, payload length and a last flag that
// marks the final event caused by a byte; cfg writes crc_init (index 0) and
// info_command_code (index 1), always ready; the user must write them only
// while the block is idle, and the block itself does not enforce this.
// A two-word input queue feeds a sequencer that owns the frame buffer, a
// circular memory with one write port and a registered read port.
// A byte that completes nothing passes idle, buffer read and STX check, and
// maybe the length check, before done. Every discarded garbage byte adds a
// further read and STX check; every event passes the emit state, and each
// event after the first a rescan; a frame that reaches the CRC check also
// walks the buffer one byte per cycle through the one memory read port.
// Reset empties the buffer, forgets the last id and restores the register
// defaults. When evt stalls, one event waits in the output register, one in
// the slot that sets the last flag and one more in the sequencer, which then
// holds; the queue takes two more bytes before rx ready drops.
`include "stx_packet_deframer_crc16_macros.svh"

module stx_packet_deframer_crc16 #(
  parameter int BUFFER_DEPTH = spd_pkg::DEF_DEPTH
) (
  input logic         clk,
  input logic         rst,
  spd_byte_if.sink    rx,
  spd_event_if.source evt,
  spd_cfg_if.sink     cfg
);

  logic [15:0]      crc_init;
  logic [7:0]       info_cmd;
  logic             q_valid;
  logic [7:0]       q_byte;
  logic             q_pop;
  spd_pkg::status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init <= 16'hFFFF;
      info_cmd <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        spd_pkg::REG_CRC_INIT: crc_init <= cfg.data;
        spd_pkg::REG_INFO_CMD: info_cmd <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  spd_in_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_valid (q_valid),
    .q_byte  (q_byte),
    .q_pop   (q_pop)
  );

  spd_engine #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_pop    (q_pop),
    .crc_init (crc_init),
    .info_cmd (info_cmd),
    .evt      (evt),
    .status   (status)
  );

  `SPD_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1,
    status.fill <= spd_pkg::STAT_W'(BUFFER_DEPTH), "buffer fill over depth")
  `SPD_ASSERT_NOW(a_bad_zero, clk, rst,
    evt.valid && (evt.event_kind == spd_pkg::EV_BAD),
    (evt.packet_cmd == 8'd0) && (evt.packet_id == 8'd0) && (evt.payload_length == 6'd0),
    "bad packet event with nonzero fields")
  `SPD_ASSERT_NOW(a_plen_bound, clk, rst,
    evt.valid && (evt.event_kind != spd_pkg::EV_BAD),
    evt.payload_length <= 6'(BUFFER_DEPTH - spd_pkg::MIN_FRAME),
    "payload length beyond buffer")
  `SPD_ASSERT_NEXT(a_idle_empty_ok, clk, rst,
    !status.busy && (status.fill == '0), status.fill <= spd_pkg::STAT_W'(1),
    "fill jumped while idle")

endmodule

[tb/stx_packet_deframer_crc16_test.sv]
// Self-checking test of the STX/length framed deframer with CRC-16 check.
// Uses spd_pkg, the spd_if interfaces and the stx_packet_deframer_crc16 top.
// A directed table runs first, then random framed traffic, over several register settings.
module stx_packet_deframer_crc16_test;

  localparam int DEPTH     = 64;
  localparam int LIMIT     = 600000;
  localparam int SETTLE    = 200;
  localparam int N_PHASES  = 4;
  localparam int PHASE_LEN = 3;

  typedef enum logic [1:0] {ROW_BYTE, ROW_FRAME, ROW_BADCRC} row_op_t;

  typedef struct {
    row_op_t         op;
    logic [7:0]      b;
    logic [7:0]      cmd;
    logic [7:0]      id;
    int              plen;
    bit              chk;
    spd_pkg::event_t want;
  } stim_row_t;

  typedef struct {
    bit              chk;
    spd_pkg::event_t want;
  } byte_check_t;

  logic clk;
  logic rst;
  spd_byte_if  rx ();
  spd_event_if evt ();
  spd_cfg_if   cfg ();

  stx_packet_deframer_crc16 #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .rx(rx.sink), .evt(evt.source), .cfg(cfg.sink)
  );

  // deframer shadow state
  logic [7:0]  frame_mem [DEPTH];
  int          fill;
  logic [7:0]  last_id;
  bit          last_id_ok;
  logic [15:0] crc_seed;
  logic [7:0]  info_cmd;

  spd_pkg::event_t events_due [$];
  byte_check_t     byte_checks [$];
  int          errors;
  int          cycles;
  int          stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic logic [15:0] crc16_buffered(int n);
    logic [15:0] c;
    c = crc_seed;
    for (int i = 0; i < n; i++) c = crc16_next(c, frame_mem[i]);
    return c;
  endfunction

  function automatic void shift_out(int n);
    if (n >= fill) begin
      fill = 0;
    end else begin
      for (int i = 0; i < fill - n; i++) frame_mem[i] = frame_mem[i + n];
      fill -= n;
    end
  endfunction

  function automatic spd_pkg::event_t make_event(logic [1:0] k, logic [7:0] c,
                                                 logic [7:0] i, int p);
    spd_pkg::event_t e;
    e.kind = k; e.cmd = c; e.id = i; e.plen = p[5:0]; e.last = 1'b0;
    return e;
  endfunction

  function automatic string event_text(spd_pkg::event_t e);
    return $sformatf("kind=%0d cmd=%02h id=%02h plen=%0d last=%0d",
                     e.kind, e.cmd, e.id, e.plen, e.last);
  endfunction

  // Advance the shadow deframer by one byte; return the events it causes.
  function automatic void deframe_byte(input logic [7:0] b, output spd_pkg::event_t evs [$]);
    int pos, len;
    logic [15:0] rxc;
    evs = {};
    if (fill >= DEPTH) fill = 0;
    frame_mem[fill] = b;
    fill++;
    while (fill > 0 && evs.size() < 64) begin
      if (frame_mem[0] != spd_pkg::STX_BYTE) begin
        pos = 0;
        while (pos < fill && frame_mem[pos] != spd_pkg::STX_BYTE) pos++;
        if (pos >= fill) begin
          fill = 0;
          break;
        end
        shift_out(pos);
      end
      if (fill < 2) break;
      len = int'(frame_mem[1]);
      if (len > DEPTH) begin
        evs.push_back(make_event(spd_pkg::EV_BAD, 8'h00, 8'h00, 0));
        shift_out(1);
        continue;
      end
      if (len > fill) break;
      if (len < spd_pkg::MIN_FRAME) begin
        evs.push_back(make_event(spd_pkg::EV_BAD, 8'h00, 8'h00, 0));
        shift_out(1);
        continue;
      end
      rxc = {frame_mem[len-1], frame_mem[len-2]};
      if (crc16_buffered(len - 2) != rxc) begin
        evs.push_back(make_event(spd_pkg::EV_BAD, 8'h00, 8'h00, 0));
        shift_out(1);
        continue;
      end
      if (last_id_ok && last_id == frame_mem[3]) begin
        evs.push_back(make_event(spd_pkg::EV_DUP, frame_mem[2], frame_mem[3],
                                 len - spd_pkg::MIN_FRAME));
      end else begin
        last_id = frame_mem[3];
        last_id_ok = 1'b1;
        evs.push_back(make_event((frame_mem[2] == info_cmd) ? spd_pkg::EV_INFO
                                                            : spd_pkg::EV_UNK,
                                 frame_mem[2], frame_mem[3], len - spd_pkg::MIN_FRAME));
      end
      shift_out(len);
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string line);
    $display("mismatch %s", line);
    errors++;
  endtask

  // predict on every accepted byte
  always @(posedge clk) begin
    spd_pkg::event_t evs [$];
    byte_check_t     bc;
    if (!rst && rx.valid && rx.ready) begin
      deframe_byte(rx.rx_byte, evs);
      bc = byte_checks.pop_front();
      if (bc.chk) begin
        if (evs.size() != 1) begin
          report_mismatch($sformatf("byte %02h gave %0d events, want 1",
                                    rx.rx_byte, evs.size()));
        end else if (evs[0] != bc.want) begin
          report_mismatch($sformatf("typed: got %s, want %s",
                                    event_text(evs[0]), event_text(bc.want)));
        end
      end
      foreach (evs[i]) events_due.push_back(evs[i]);
    end
  end

  // check every accepted event word
  always @(posedge clk) begin
    spd_pkg::event_t got;
    spd_pkg::event_t want;
    if (!rst && evt.valid && evt.ready) begin
      got.kind = evt.event_kind; got.cmd = evt.packet_cmd; got.id = evt.packet_id;
      got.plen = evt.payload_length; got.last = evt.last_event;
      if (events_due.size() == 0) begin
        report_mismatch($sformatf("unexpected event %s", event_text(got)));
      end else begin
        want = events_due.pop_front();
        if (got != want) begin
          report_mismatch($sformatf("event: got %s, want %s",
                                    event_text(got), event_text(want)));
        end
      end
    end
  end

  // receiver stalls on its own pattern
  always @(negedge clk) begin
    if (cycles % 97 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
    evt.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit chk = 1'b0, spd_pkg::event_t want = '0);
    byte_check_t bc;
    bc.chk = chk; bc.want = want;
    byte_checks.push_back(bc);
    @(negedge clk);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    rx.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Send one frame; bad_crc flips a CRC bit.
  task automatic send_frame(logic [7:0] c, logic [7:0] i, int plen, bit bad_crc,
                            bit chk = 1'b0, spd_pkg::event_t want = '0);
    logic [7:0]  fr [$];
    logic [15:0] crc;
    fr = {spd_pkg::STX_BYTE, 8'(plen + spd_pkg::MIN_FRAME), c, i};
    for (int k = 0; k < plen; k++) fr.push_back(8'($urandom_range(0, 255)));
    crc = crc_seed;
    foreach (fr[k]) crc = crc16_next(crc, fr[k]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    foreach (fr[k]) send_byte(fr[k], (k == fr.size() - 1) ? chk : 1'b0, want);
  endtask

  task automatic write_reg(logic [spd_pkg::IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    if (idx == spd_pkg::REG_CRC_INIT) crc_seed = val;
    else if (idx == spd_pkg::REG_INFO_CMD) info_cmd = val[7:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain_events();
    pause_sender(0);
    while (events_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  stim_row_t rows [$];

  initial begin
    logic [7:0] rand_cmd, rand_id;
    int burst;
    errors = 0; cycles = 0; stall_pct = 0;
    fill = 0; last_id = 0; last_id_ok = 0; crc_seed = 16'hFFFF; info_cmd = 8'h00;
    rx.valid = 1'b0; rx.rx_byte = 8'h00;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows = '{
      '{ROW_BYTE, 8'h55, 0, 0, 0, 0, '0},
      '{ROW_BYTE, 8'hAA, 0, 0, 0, 0, '0},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 0, '0},
      '{ROW_BYTE, 8'd3, 0, 0, 0, 0, '0},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 1,
        '{spd_pkg::EV_BAD, 8'h00, 8'h00, 6'd0, 1'b1}},
      '{ROW_BYTE, 8'd65, 0, 0, 0, 1, '{spd_pkg::EV_BAD, 8'h00, 8'h00, 6'd0, 1'b1}},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 0, '0},
      '{ROW_BYTE, 8'hFF, 0, 0, 0, 1, '{spd_pkg::EV_BAD, 8'h00, 8'h00, 6'd0, 1'b1}},
      '{ROW_FRAME, 0, 8'h00, 8'h01, 0, 1, '{spd_pkg::EV_INFO, 8'h00, 8'h01, 6'd0, 1'b1}},
      '{ROW_FRAME, 0, 8'h00, 8'h01, 0, 1, '{spd_pkg::EV_DUP, 8'h00, 8'h01, 6'd0, 1'b1}},
      '{ROW_FRAME, 0, 8'hFF, 8'hFF, 58, 1, '{spd_pkg::EV_UNK, 8'hFF, 8'hFF, 6'd58, 1'b1}},
      '{ROW_BADCRC, 0, 8'h05, 8'h07, 2, 0, '0},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 0, '0},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 0, '0},
      '{ROW_BYTE, 8'h00, 0, 0, 0, 0, '0},
      '{ROW_FRAME, 0, 8'h80, 8'h00, 1, 0, '0},
      '{ROW_BYTE, spd_pkg::STX_BYTE, 0, 0, 0, 0, '0},
      '{ROW_BYTE, 8'd64, 0, 0, 0, 0, '0},
      '{ROW_BADCRC, 0, 8'h11, 8'h22, 56, 0, '0},
      '{ROW_FRAME, 0, 8'h7F, 8'h02, 3, 0, '0}
    };
    foreach (rows[r]) begin
      case (rows[r].op)
        ROW_BYTE:   send_byte(rows[r].b, rows[r].chk, rows[r].want);
        ROW_FRAME:  send_frame(rows[r].cmd, rows[r].id, rows[r].plen, 1'b0, rows[r].chk,
                               rows[r].want);
        ROW_BADCRC: send_frame(rows[r].cmd, rows[r].id, rows[r].plen, 1'b1);
        default: ;
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // hold until the block is idle, then change the settings
      drain_events();
      case (ph)
        0: begin
          write_reg(spd_pkg::REG_CRC_INIT, 16'h0000);
          write_reg(spd_pkg::REG_INFO_CMD, 16'h00FF);
        end
        1: begin
          write_reg(spd_pkg::REG_CRC_INIT, 16'hFFFF);
          write_reg(spd_pkg::REG_INFO_CMD, 16'h0000);
        end
        2: begin
          write_reg(spd_pkg::REG_CRC_INIT, 16'h1D0F);
          write_reg(spd_pkg::REG_INFO_CMD, 16'h0042);
        end
        default: begin
          write_reg(spd_pkg::REG_CRC_INIT, 16'($urandom_range(0, 65535)));
          write_reg(spd_pkg::REG_INFO_CMD, 16'($urandom_range(0, 255)));
        end
      endcase
      burst = $urandom_range(1, 6);
      for (int n = 0; n < PHASE_LEN; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        rand_cmd = ($urandom_range(0, 3) == 0) ? info_cmd : 8'($urandom_range(0, 255));
        rand_id  = ($urandom_range(0, 4) == 0) ? last_id : 8'($urandom_range(0, 255));
        if (pick < 70) begin
          send_frame(rand_cmd, rand_id,
                     ($urandom_range(0, 19) == 0) ? 58 : $urandom_range(0, 6), 1'b0);
        end else if (pick < 80) begin
          send_frame(rand_cmd, rand_id, $urandom_range(0, 8), 1'b1);
        end else if (pick < 85) begin
          send_byte(spd_pkg::STX_BYTE);
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(($urandom_range(0, 3) == 0) ? spd_pkg::STX_BYTE
                                                : 8'($urandom_range(0, 255)));
        end
        if (--burst == 0) begin
          pause_sender($urandom_range(0, 12));
          burst = $urandom_range(1, 8);
        end
      end
    end

    drain_events();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[stx_packet_deframer_crc16.f]
+incdir+design
design/spd_pkg.sv
design/spd_if.sv
design/spd_in_fifo.sv
design/spd_engine.sv
design/stx_packet_deframer_crc16.sv
tb/stx_packet_deframer_crc16_test.sv
